FILE: design/tcm_pkg.sv
`timescale 1ns / 1ps

package tcm_pkg;

	localparam int TASK_COUNT_DEF = 8;

	localparam int DUR_W  = 24;
	localparam int TIME_W = 32;
	localparam int PCT_W  = 8;
	localparam int TASK_W = 3;
	localparam int FUNC_W = 2;

	localparam logic [DUR_W-1:0] FRAME_RELOAD_RST = 24'd10240;

	// percent arithmetic: x*10 as (x<<3)+(x<<1), /1024 as a bit slice,
	// p*100 as (p<<6)+(p<<5)+(p<<2)
	localparam int PCT_SHIFT = 10;
	localparam logic [PCT_W-1:0] PCT_WRAP_HI = 8'd200;
	localparam logic [PCT_W-1:0] PCT_WRAP_LO = 8'd100;

	localparam logic [FUNC_W-1:0] FN_TICK   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_START  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_FINISH = 2'd2;
	localparam logic [FUNC_W-1:0] FN_QUERY  = 2'd3;

	typedef struct packed {
		logic [TIME_W-1:0] a;
		logic [TIME_W-1:0] b;
		logic              sub;
	} alu_req_t;

endpackage

FILE: design/tcm_ram.sv
`timescale 1ns / 1ps

module tcm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/tcm_alu.sv
`timescale 1ns / 1ps

module tcm_alu
	import tcm_pkg::*;
(
	input  alu_req_t          req,
	output logic [TIME_W-1:0] y
);

	logic [TIME_W-1:0] b_c;

	assign b_c = req.sub ? ~req.b : req.b;
	assign y   = req.a + b_c + TIME_W'(req.sub);

endmodule

FILE: design/task_cpu_time_monitor_top.sv
`timescale 1ns / 1ps

// One item at a time: an input beat takes the sequencer through EXEC and OUT
// for start and for a tick that does not end a frame, EXEC, CHG and OUT for
// finish and frame-end ticks, EXEC, Q10, QP1, QP2, QSUB and OUT for queries,
// stepping the shared 32-bit adder and the single store read port.
// arst_n clears all control state; per-entry valid bits make the whole store
// read as zero right after reset, so no clearing pass is needed.
module task_cpu_time_monitor_top
	import tcm_pkg::*;
#(
	parameter int TASK_COUNT = TASK_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [DUR_W-1:0]  cfg_wr_data,    // frame_reload
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,   // running_task[2:0], query_task[5:3]
	input  logic [FUNC_W-1:0] s_axis_tuser,   // func[1:0]
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [47:0]       m_axis_tdata,   // raw_time[31:0], pct_integer[39:32],
	                                          // pct_fraction[47:40]
	output logic              m_axis_tuser    // frame_swapped
);

	localparam int DEPTH = 2 * TASK_COUNT;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_CHG  = 3'd2;
	localparam logic [2:0] S_Q10  = 3'd3;
	localparam logic [2:0] S_QP1  = 3'd4;
	localparam logic [2:0] S_QP2  = 3'd5;
	localparam logic [2:0] S_QSUB = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	logic [2:0]        state_q;
	logic [DUR_W-1:0]  frame_reload_q;
	logic [DUR_W-1:0]  dur_q;
	logic              running_q;
	logic [DUR_W-1:0]  frame_q;
	logic              bank_q;
	logic [DEPTH-1:0]  valid_q;

	logic [FUNC_W-1:0] func_q;
	logic [TASK_W-1:0] run_task_q;
	logic [TASK_W-1:0] qry_task_q;
	logic              hit_q;
	logic              in_range_q;
	logic [AW-1:0]     addr_q;
	logic [TIME_W-1:0] raw_q;
	logic [TIME_W-1:0] acc_q;
	logic [PCT_W-1:0]  pint_q;
	logic              swapped_q;

	logic              m_valid_q;
	logic [47:0]       m_data_q;
	logic              m_user_q;

	logic              in_fire;
	logic              out_load;
	logic              is_query;
	logic [TASK_W-1:0] sel_task;
	logic              sel_bank;
	logic              sel_in_range;
	logic [AW-1:0]     rd_addr_c;
	logic [TIME_W-1:0] rd_data;
	logic [TIME_W-1:0] rd_val_c;
	logic [TIME_W-1:0] alu_y;
	alu_req_t          alu_req;
	logic              ram_we;
	logic [PCT_W-1:0]  frac_raw_c;
	logic [PCT_W-1:0]  frac_c;

	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign out_load      = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

	// query reads the finished bank, a charge the active one
	assign is_query     = (func_q == FN_QUERY);
	assign sel_task     = is_query ? qry_task_q : run_task_q;
	assign sel_bank     = is_query ? ~bank_q : bank_q;
	assign sel_in_range = (32'(sel_task) < TASK_COUNT);
	assign rd_addr_c    = AW'(sel_task) + (sel_bank ? AW'(TASK_COUNT) : AW'(0));

	assign rd_val_c = hit_q ? rd_data : '0;
	assign ram_we   = (state_q == S_CHG) && in_range_q;

	tcm_ram #(
		.WIDTH(TIME_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_q),
		.wdata(alu_y),
		.raddr(rd_addr_c),
		.rdata(rd_data)
	);

	always_comb begin
		alu_req = '0;
		unique case (state_q)
			S_CHG: begin
				alu_req.a = rd_val_c;
				alu_req.b = {{(TIME_W-DUR_W){1'b0}}, dur_q};
			end
			S_Q10: begin
				alu_req.a = {rd_val_c[TIME_W-4:0], 3'b0};
				alu_req.b = {rd_val_c[TIME_W-2:0], 1'b0};
			end
			S_QP1: begin
				alu_req.a = {18'b0, acc_q[PCT_SHIFT+PCT_W-1:PCT_SHIFT], 6'b0};
				alu_req.b = {19'b0, acc_q[PCT_SHIFT+PCT_W-1:PCT_SHIFT], 5'b0};
			end
			S_QP2: begin
				alu_req.a = acc_q;
				alu_req.b = {22'b0, pint_q, 2'b0};
			end
			S_QSUB: begin
				alu_req.a   = raw_q;
				alu_req.b   = acc_q;
				alu_req.sub = 1'b1;
			end
			default: begin
				alu_req = '0;
			end
		endcase
	end

	tcm_alu u_alu (
		.req(alu_req),
		.y  (alu_y)
	);

	assign frac_raw_c = acc_q[PCT_W-1:0];

	always_comb begin
		priority if (frac_raw_c >= PCT_WRAP_HI) begin
			frac_c = frac_raw_c - PCT_WRAP_HI;
		end else if (frac_raw_c >= PCT_WRAP_LO) begin
			frac_c = frac_raw_c - PCT_WRAP_LO;
		end else begin
			frac_c = frac_raw_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_reload_q <= FRAME_RELOAD_RST;
		end else if (cfg_wr_en) begin
			frame_reload_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			dur_q     <= '0;
			running_q <= 1'b0;
			frame_q   <= '0;
			bank_q    <= 1'b0;
			valid_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (func_q)
						FN_TICK: begin
							if (running_q) begin
								dur_q <= dur_q + DUR_W'(1);
							end
							if (frame_q >= frame_reload_q) begin
								state_q <= S_CHG;
							end else begin
								frame_q <= frame_q + DUR_W'(1);
								state_q <= S_OUT;
							end
						end
						FN_START: begin
							dur_q     <= '0;
							running_q <= 1'b1;
							state_q   <= S_OUT;
						end
						FN_FINISH: begin
							state_q <= S_CHG;
						end
						FN_QUERY: begin
							state_q <= S_Q10;
						end
						default: begin
							state_q <= S_OUT;
						end
					endcase
				end
				S_CHG: begin
					dur_q <= '0;
					if (func_q == FN_FINISH) begin
						running_q <= 1'b0;
					end
					if (func_q == FN_TICK) begin
						// swap banks and drop the new active bank's contents
						bank_q  <= ~bank_q;
						frame_q <= '0;
						for (int i = 0; i < DEPTH; i++) begin
							if ((i >= TASK_COUNT) != bank_q) begin
								valid_q[i] <= 1'b0;
							end
						end
					end
					if (ram_we) begin
						valid_q[addr_q] <= 1'b1;
					end
					state_q <= S_OUT;
				end
				S_Q10: state_q <= S_QP1;
				S_QP1: state_q <= S_QP2;
				S_QP2: state_q <= S_QSUB;
				S_QSUB: state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload and arithmetic scratch
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q     <= s_axis_tuser;
			run_task_q <= s_axis_tdata[2:0];
			qry_task_q <= s_axis_tdata[5:3];
			raw_q      <= '0;
			acc_q      <= '0;
			pint_q     <= '0;
			swapped_q  <= 1'b0;
		end
		unique case (state_q)
			S_EXEC: begin
				addr_q     <= rd_addr_c;
				in_range_q <= sel_in_range;
				hit_q      <= sel_in_range && valid_q[rd_addr_c];
			end
			S_CHG: begin
				swapped_q <= (func_q == FN_TICK);
			end
			S_Q10: begin
				raw_q <= rd_val_c;
				acc_q <= alu_y;
			end
			S_QP1: begin
				pint_q <= acc_q[PCT_SHIFT+PCT_W-1:PCT_SHIFT];
				acc_q  <= alu_y;
			end
			S_QP2, S_QSUB: begin
				acc_q <= alu_y;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {frac_c, pint_q, raw_q};
			m_user_q <= swapped_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

`ifndef SYNTHESIS
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !in_fire) |=> (state_q == S_IDLE))
		else $error("sequencer left idle without an input beat");

	a_write_in_charge: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CHG && func_q != FN_QUERY))
		else $error("store written outside a charge step");

	a_frame_end_swaps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHG && func_q == FN_TICK) |=> (bank_q != $past(bank_q)))
		else $error("frame end did not toggle the bank");

	a_nonquery_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && func_q != FN_QUERY) |-> (raw_q == '0 && pint_q == '0))
		else $error("non-query item carries time data");
`endif

endmodule
